>>> design/umask_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the tap-weight helper function of the unsharp mask stream unit.
package umask_pkg;

  localparam int PIX_BITS      = 16;
  localparam int WEIGHT_BITS   = 12;
  localparam int CFG_W_BITS    = 60;
  localparam int NUM_WEIGHTS   = CFG_W_BITS / WEIGHT_BITS;
  localparam int HB_BITS       = 20;
  localparam int HACC_BITS     = 32;
  localparam int VACC_BITS     = 36;
  localparam int AMT_BITS      = 11;
  localparam int THR_BITS      = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 60;
  localparam int HB_RND        = 1 << (WEIGHT_BITS - 5);
  localparam int HB_SHIFT      = WEIGHT_BITS - 4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_WEIGHTS = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AMOUNT         = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD      = 3'd5;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [12:0]            RST_IMAGE_WIDTH  = 13'd4096;
  localparam logic [15:0]            RST_IMAGE_HEIGHT = 16'd4096;
  localparam logic [2:0]             RST_RADIUS       = 3'd4;
  localparam logic [CFG_W_BITS-1:0]  RST_WEIGHTS      = 60'd31825372575048516;
  localparam logic [AMT_BITS-1:0]    RST_AMOUNT       = 11'd128;
  localparam logic [THR_BITS-1:0]    RST_THRESHOLD    = 16'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_HTAP,
    ST_HWR,
    ST_VTAP,
    ST_VLAST,
    ST_CALC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic in_rdy;
    logic load;
    logic htap;
    logic hwr;
    logic vtap;
    logic vlast;
    logic outld;
  } ctl_t;

  typedef struct packed {
    logic [AMT_BITS-1:0] amount;
    logic [THR_BITS-1:0] threshold;
  } sharp_cfg_t;

  // Tap weight at distance d; fields past the packed register read as zero.
  function automatic logic [WEIGHT_BITS-1:0] weight_of(input logic [CFG_W_BITS-1:0] wv,
                                                       input int d);
    logic [WEIGHT_BITS-1:0] w;
    w = '0;
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      if (d == i) w = wv[i*WEIGHT_BITS +: WEIGHT_BITS];
    end
    return w;
  endfunction

endpackage

>>> design/umask_row_mem.sv
`timescale 1ns / 1ps
// Simple dual-port row store with one write port and a registered read port.
module umask_row_mem #(
  parameter int DW    = 16,
  parameter int DEPTH = 36864
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/umask_sharp.sv
`timescale 1ns / 1ps
// Three-stage sharpening datapath: blur rounding, gain multiply, clamp and saturation.
module umask_sharp import umask_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [VACC_BITS-1:0] vs,
  input  logic [PIX_BITS-1:0]  orig,
  input  sharp_cfg_t           cfg,
  output logic                 done,
  output logic [PIX_BITS-1:0]  result
);

  logic               v1_r, v2_r, v3_r;
  logic signed [25:0] diff1_r;
  logic               below1_r, below2_r;
  logic [15:0]        orig1_r, orig2_r;
  logic signed [37:0] prod2_r;
  logic [26:0]        lim2_r;

  logic [VACC_BITS:0] bsum;
  logic [24:0]        blur;
  logic signed [25:0] diff;
  logic [25:0]        adiff;
  logic signed [39:0] base_s, lim_s, s, hi, lo, rnd;
  logic [15:0]        res_nxt;

  always_comb begin
    bsum  = {1'b0, vs} + (VACC_BITS+1)'(2048);
    blur  = bsum[36:12];
    diff  = $signed({6'b0, orig, 4'b0}) - $signed({1'b0, blur});
    adiff = diff[25] ? 26'(-diff) : 26'(diff);
  end

  // Clamp to the overshoot band, then round and saturate.
  always_comb begin
    base_s = $signed({12'b0, orig2_r, 12'b0});
    lim_s  = $signed({9'b0, lim2_r, 4'b0});
    s      = base_s + $signed({{2{prod2_r[37]}}, prod2_r});
    hi     = base_s + lim_s;
    lo     = base_s - lim_s;
    if (s > hi) s = hi;
    if (s < lo) s = lo;
    rnd = s + 40'sd2048;
    if (below2_r) begin
      res_nxt = orig2_r;
    end else if (s < 0) begin
      res_nxt = '0;
    end else if (|rnd[39:28]) begin
      res_nxt = '1;
    end else begin
      res_nxt = rnd[27:12];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      diff1_r  <= diff;
      below1_r <= adiff < {6'b0, cfg.threshold, 4'b0};
      orig1_r  <= orig;
    end
    if (v1_r) begin
      prod2_r  <= $signed({1'b0, cfg.amount}) * diff1_r;
      lim2_r   <= 27'(cfg.amount) * 27'(cfg.threshold);
      below2_r <= below1_r;
      orig2_r  <= orig1_r;
    end
    if (v2_r) begin
      result <= res_nxt;
    end
  end

  assign done = v3_r;

endmodule

>>> design/unsharp_mask_stream_unit.sv
`timescale 1ns / 1ps
// Top level of the streaming unsharp mask with thresholded, clamped gain.
//
// Usage: pixels enter in raster order on the in_ channel (valid/ready), one
// transaction per pixel, with in_command set to pixel. Each result leaves on
// the out_ channel with end_of_row and end_of_frame marks. Output pixel m is
// produced by the transaction that brings input pixel m + R*W + R; after the
// last pixel of a frame, drain transactions push the pending outputs out, one
// each. Configuration is written through cfg_wr_en/cfg_index/cfg_data while
// the block is idle; any valid write restarts the frame.
// The block takes one transaction at a time. A pixel is loaded, then each
// horizontal blur column that it finishes (none early in a row, one, or
// min(R+1, W) at the end of a row) is tapped and written; the vertical taps,
// sharpening and output follow unless the pixel produces no output. A drain
// runs only the vertical part. Taps go one per cycle through the shared
// multiply-accumulate units and the single read port of each row memory.
// Reset clears all counters and the pixel window; row memories are not
// cleared. A stalled receiver holds the result in the output register; the
// next transaction is accepted meanwhile and waits only when its own result
// is ready.
module unsharp_mask_stream_unit import umask_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_RADIUS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_command,
  input  logic [PIX_BITS-1:0]      in_pixel_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PIX_BITS-1:0]      out_pixel_out,
  output logic                     out_end_of_row,
  output logic                     out_end_of_frame,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int WIN   = 2 * MAX_RADIUS + 1;
  localparam int DEPTH = WIN * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int PW    = $clog2(WIN);
  localparam int NW    = WW + 16;
  localparam int OFFW  = RW + WW;

  // Configuration registers.
  logic [12:0]            image_width_r;
  logic [15:0]            image_height_r;
  logic [2:0]             kernel_radius_r;
  logic [CFG_W_BITS-1:0]  kernel_weights_r;
  logic [AMT_BITS-1:0]    amount_r;
  logic [THR_BITS-1:0]    threshold_r;
  logic                   cfg_restart;

  logic [WW-1:0]          w_eff;
  logic [15:0]            h_eff;
  logic [RW-1:0]          rad_eff;
  logic [NW-1:0]          total_r, lag_r;

  state_t                 state_r, state_nxt;
  ctl_t                   ctl;

  // Frame position counters.
  logic [CW-1:0]          in_col_r, out_col_r;
  logic [15:0]            in_row_r, out_row_r;
  logic [NW-1:0]          in_cnt_r, out_cnt_r;
  logic [AW-1:0]          in_addr_r, out_addr_r;
  logic [PIX_BITS-1:0]    win_r [WIN];

  // Per-transaction work registers.
  logic                   cmd_r;
  logic [PIX_BITS-1:0]    pix_r;
  logic [CW-1:0]          j_r;
  logic [AW-1:0]          pix_addr_r;
  logic [RW-1:0]          dist_r, dist_lo_r;
  logic signed [RW:0]     d_r, vd_r;
  logic                   emit_r;
  logic [HACC_BITS-1:0]   hacc_r;
  logic [VACC_BITS-1:0]   vacc_r;
  logic                   vacc_en_r;
  logic [WEIGHT_BITS-1:0] vw_r;
  logic                   start_r;

  logic                   out_valid_r, out_eor_r, out_eof_r;
  logic [PIX_BITS-1:0]    out_pix_r;

  logic                   last_col, pixel_go, drain_go, has_hb, emit_now;
  logic [RW-1:0]          dist_hi;
  logic                   frame_end, out_last_col;
  logic signed [RW:0]     rad_s;

  logic [PW-1:0]          win_idx;
  logic [WEIGHT_BITS-1:0] w_h;
  logic [AW:0]            hb_addr_w;
  logic [HACC_BITS:0]     hb_rnd;
  logic [HB_BITS-1:0]     hb_val;
  logic [AW:0]            v_addr_w;
  logic [WEIGHT_BITS-1:0] w_v;

  logic [HB_BITS-1:0]     hb_rd;
  logic [PIX_BITS-1:0]    orig_rd;
  logic                   sharp_done;
  logic [PIX_BITS-1:0]    sharp_res;
  sharp_cfg_t             sharp_cfg;

  // Effective configuration values.
  always_comb begin
    if (image_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width_r);
    end
    h_eff = (image_height_r == '0) ? 16'd1 : image_height_r;
    if (kernel_radius_r == '0) begin
      rad_eff = RW'(1);
    end else if (32'(kernel_radius_r) > MAX_RADIUS) begin
      rad_eff = RW'(MAX_RADIUS);
    end else begin
      rad_eff = RW'(kernel_radius_r);
    end
    rad_s = $signed({1'b0, rad_eff});
  end

  assign cfg_restart = cfg_wr_en && (cfg_index == CFG_IMAGE_WIDTH
                       || cfg_index == CFG_IMAGE_HEIGHT || cfg_index == CFG_KERNEL_RADIUS
                       || cfg_index == CFG_KERNEL_WEIGHTS || cfg_index == CFG_AMOUNT
                       || cfg_index == CFG_THRESHOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r    <= RST_IMAGE_WIDTH;
      image_height_r   <= RST_IMAGE_HEIGHT;
      kernel_radius_r  <= RST_RADIUS;
      kernel_weights_r <= RST_WEIGHTS;
      amount_r         <= RST_AMOUNT;
      threshold_r      <= RST_THRESHOLD;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:    image_width_r    <= cfg_data[12:0];
        CFG_IMAGE_HEIGHT:   image_height_r   <= cfg_data[15:0];
        CFG_KERNEL_RADIUS:  kernel_radius_r  <= cfg_data[2:0];
        CFG_KERNEL_WEIGHTS: kernel_weights_r <= cfg_data[CFG_W_BITS-1:0];
        CFG_AMOUNT:         amount_r         <= cfg_data[AMT_BITS-1:0];
        CFG_THRESHOLD:      threshold_r      <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Frame size and pipeline lag are registered once per cycle from the
  // configuration; they settle before any transaction reaches them.
  always_ff @(posedge clk) begin
    total_r <= NW'(w_eff) * NW'(h_eff);
    lag_r   <= NW'(rad_eff) * NW'(w_eff) + NW'(rad_eff);
  end

  // Decisions taken in the load cycle.
  always_comb begin
    last_col = (WW'(in_col_r) == w_eff - WW'(1));
    pixel_go = (cmd_r == CMD_PIXEL) && (in_row_r < h_eff);
    drain_go = !pixel_go && (in_row_r >= h_eff) && (out_cnt_r < total_r);
    has_hb   = (int'(in_col_r) >= int'(rad_eff)) || last_col;
    dist_hi  = (int'(in_col_r) >= int'(rad_eff)) ? rad_eff : RW'(in_col_r);
    emit_now = {1'b0, in_cnt_r} >= ({1'b0, lag_r} + {1'b0, out_cnt_r});
  end

  // Horizontal tap: pick the window entry, replicating edge pixels.
  always_comb begin
    int t, p, da;
    t  = int'(dist_r) - int'(d_r);
    if (t < 0) begin
      p = 0;
    end else if (t > int'(j_r)) begin
      p = int'(j_r);
    end else begin
      p = t;
    end
    if (p > WIN - 1) p = WIN - 1;
    win_idx = PW'(p);
    da  = (d_r < 0) ? -int'(d_r) : int'(d_r);
    w_h = weight_of(kernel_weights_r, da);
  end

  // Horizontal result: round to four fraction bits and saturate.
  always_comb begin
    logic [AW:0] de;
    de = (AW+1)'(dist_r);
    if ({1'b0, pix_addr_r} >= de) begin
      hb_addr_w = {1'b0, pix_addr_r} - de;
    end else begin
      hb_addr_w = {1'b0, pix_addr_r} + (AW+1)'(DEPTH) - de;
    end
    hb_rnd = {1'b0, hacc_r} + (HACC_BITS+1)'(HB_RND);
    hb_rnd = hb_rnd >> HB_SHIFT;
    hb_val = (|hb_rnd[HACC_BITS:HB_BITS]) ? '1 : hb_rnd[HB_BITS-1:0];
  end

  // Vertical tap address, with top and bottom rows replicated.
  always_comb begin
    int ysum, rel, ra;
    logic [OFFW-1:0] off;
    logic [AW:0]     offe;
    ysum = int'(out_row_r) + int'(vd_r);
    if (ysum < 0) begin
      rel = -int'(out_row_r);
    end else if (ysum > int'(h_eff) - 1) begin
      rel = int'(h_eff) - 1 - int'(out_row_r);
    end else begin
      rel = int'(vd_r);
    end
    ra   = (rel < 0) ? -rel : rel;
    off  = OFFW'(RW'(ra)) * OFFW'(w_eff);
    offe = (AW+1)'(off);
    if (rel < 0) begin
      if ({1'b0, out_addr_r} >= offe) begin
        v_addr_w = {1'b0, out_addr_r} - offe;
      end else begin
        v_addr_w = {1'b0, out_addr_r} + (AW+1)'(DEPTH) - offe;
      end
    end else begin
      v_addr_w = {1'b0, out_addr_r} + offe;
      if (v_addr_w >= (AW+1)'(DEPTH)) v_addr_w = v_addr_w - (AW+1)'(DEPTH);
    end
    w_v = weight_of(kernel_weights_r, (vd_r < 0) ? -int'(vd_r) : int'(vd_r));
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (pixel_go) begin
          if (has_hb) begin
            state_nxt = ST_HTAP;
          end else begin
            state_nxt = emit_now ? ST_VTAP : ST_IDLE;
          end
        end else if (drain_go) begin
          state_nxt = ST_VTAP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_HTAP:  if (d_r == rad_s) state_nxt = ST_HWR;
      ST_HWR: begin
        if (dist_r == dist_lo_r) begin
          state_nxt = emit_r ? ST_VTAP : ST_IDLE;
        end else begin
          state_nxt = ST_HTAP;
        end
      end
      ST_VTAP:  if (vd_r == rad_s) state_nxt = ST_VLAST;
      ST_VLAST: state_nxt = ST_CALC;
      ST_CALC:  if (sharp_done) state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control strobes decoded from the state.
  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE:  ctl.in_rdy = 1'b1;
      ST_LOAD:  ctl.load   = 1'b1;
      ST_HTAP:  ctl.htap   = 1'b1;
      ST_HWR:   ctl.hwr    = 1'b1;
      ST_VTAP:  ctl.vtap   = 1'b1;
      ST_VLAST: ctl.vlast  = 1'b1;
      ST_CALC:  ;
      ST_OUT:   ctl.outld  = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  assign in_ready     = ctl.in_rdy;
  assign out_last_col = (WW'(out_col_r) == w_eff - WW'(1));
  assign frame_end    = ctl.outld && (out_cnt_r + NW'(1) == total_r);

  // Control state: FSM, counters and the pixel window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_cnt_r    <= '0;
      in_addr_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_cnt_r   <= '0;
      out_addr_r  <= '0;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
      vacc_en_r   <= 1'b0;
      for (int i = 0; i < WIN; i++) win_r[i] <= '0;
    end else begin
      state_r   <= state_nxt;
      start_r   <= ctl.vlast;
      vacc_en_r <= ctl.vtap;
      if (out_ready) out_valid_r <= 1'b0;
      if (ctl.outld) out_valid_r <= 1'b1;

      if (ctl.load && pixel_go) begin
        for (int i = WIN - 1; i > 0; i--) begin
          win_r[i] <= (in_col_r == '0) ? pix_r : win_r[i-1];
        end
        win_r[0]  <= pix_r;
        in_cnt_r  <= in_cnt_r + NW'(1);
        in_addr_r <= (in_addr_r == AW'(DEPTH - 1)) ? '0 : in_addr_r + AW'(1);
        if (last_col) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + 16'd1;
        end else begin
          in_col_r <= in_col_r + CW'(1);
        end
      end

      if (ctl.outld) begin
        out_cnt_r  <= out_cnt_r + NW'(1);
        out_addr_r <= (out_addr_r == AW'(DEPTH - 1)) ? '0 : out_addr_r + AW'(1);
        if (out_last_col) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + 16'd1;
        end else begin
          out_col_r <= out_col_r + CW'(1);
        end
      end

      // The last output of a frame, or a configuration write, starts over.
      if (frame_end || cfg_restart) begin
        in_col_r   <= '0;
        in_row_r   <= '0;
        in_cnt_r   <= '0;
        in_addr_r  <= '0;
        out_col_r  <= '0;
        out_row_r  <= '0;
        out_cnt_r  <= '0;
        out_addr_r <= '0;
        for (int i = 0; i < WIN; i++) win_r[i] <= '0;
      end
    end
  end

  // Work registers of the transaction in progress.
  always_ff @(posedge clk) begin
    if (ctl.in_rdy && in_valid) begin
      cmd_r <= in_command;
      pix_r <= in_pixel_in;
    end
    if (ctl.load) begin
      j_r        <= in_col_r;
      pix_addr_r <= in_addr_r;
      dist_r     <= dist_hi;
      dist_lo_r  <= last_col ? '0 : rad_eff;
      emit_r     <= emit_now;
      d_r        <= -rad_s;
      vd_r       <= -rad_s;
      hacc_r     <= '0;
    end
    if (ctl.htap) begin
      hacc_r <= hacc_r + HACC_BITS'(w_h) * HACC_BITS'(win_r[win_idx]);
      d_r    <= d_r + $signed((RW+1)'(1));
    end
    if (ctl.hwr) begin
      hacc_r <= '0;
      d_r    <= -rad_s;
      dist_r <= dist_r - RW'(1);
    end
    if (ctl.vtap) begin
      vw_r <= w_v;
      vd_r <= vd_r + $signed((RW+1)'(1));
    end
    if (!(ctl.vtap || ctl.vlast)) begin
      vacc_r <= '0;
    end else if (vacc_en_r) begin
      vacc_r <= vacc_r + VACC_BITS'(vw_r) * VACC_BITS'(hb_rd);
    end
    if (ctl.outld) begin
      out_pix_r <= sharp_res;
      out_eor_r <= out_last_col;
      out_eof_r <= out_cnt_r + NW'(1) == total_r;
    end
  end

  umask_row_mem #(.DW(PIX_BITS), .DEPTH(DEPTH)) u_orig_mem (
    .clk   (clk),
    .we    (ctl.load && pixel_go),
    .waddr (in_addr_r),
    .wdata (pix_r),
    .re    (ctl.vtap),
    .raddr (out_addr_r),
    .rdata (orig_rd)
  );

  umask_row_mem #(.DW(HB_BITS), .DEPTH(DEPTH)) u_hb_mem (
    .clk   (clk),
    .we    (ctl.hwr),
    .waddr (hb_addr_w[AW-1:0]),
    .wdata (hb_val),
    .re    (ctl.vtap),
    .raddr (v_addr_w[AW-1:0]),
    .rdata (hb_rd)
  );

  assign sharp_cfg.amount    = amount_r;
  assign sharp_cfg.threshold = threshold_r;

  umask_sharp u_sharp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .vs     (vacc_r),
    .orig   (orig_rd),
    .cfg    (sharp_cfg),
    .done   (sharp_done),
    .result (sharp_res)
  );

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = out_pix_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_frame = out_eof_r;

  // No output is produced ahead of the input that causes it.
  a_out_not_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r <= in_cnt_r)
    else $error("output count ran ahead of input count");

  // The vertical pass only runs while an output of the frame is pending.
  a_vtap_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_VTAP |-> out_cnt_r < total_r)
    else $error("vertical pass with no pending output");

  // Horizontal blur columns stay inside the range chosen at load.
  a_hb_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HTAP |-> dist_r >= dist_lo_r)
    else $error("horizontal column outside its range");

  // The sharpening pipeline finishes only while the sequencer waits for it.
  a_sharp_done: assert property (@(posedge clk) disable iff (!rst_n)
    sharp_done |-> state_r == ST_CALC)
    else $error("sharpening result arrived outside the wait state");

endmodule

>>> test/umask_sharpen_checker.sv
`timescale 1ns / 1ps
// Checker that predicts and compares the sharpened pixel stream of the unit.
module umask_sharpen_checker import umask_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_command,
  input  logic [PIX_BITS-1:0]      in_pixel_in,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [PIX_BITS-1:0]      out_pixel_out,
  input  logic                     out_end_of_row,
  input  logic                     out_end_of_frame,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       mismatch_count,
  output int                       pending_count
);

  localparam int MAXW  = 4096;
  localparam int MAXR  = 4;
  localparam int WINN  = 2 * MAXR + 1;
  localparam int DEPTH = WINN * MAXW;

  typedef struct packed {
    logic [PIX_BITS-1:0] pix;
    logic                eor;
    logic                eof;
  } sharp_result_t;

  sharp_result_t sharpened_q[$];

  logic [12:0]           img_w;
  logic [15:0]           img_h;
  logic [2:0]            radius;
  logic [CFG_W_BITS-1:0] weights;
  logic [AMT_BITS-1:0]   gain;
  logic [THR_BITS-1:0]   thresh;

  logic [PIX_BITS-1:0] orig_mem [DEPTH];
  logic [HB_BITS-1:0]  hblur_mem [DEPTH];
  logic [PIX_BITS-1:0] row_win [WINN];
  int in_col, in_row, out_col, out_row;

  assign pending_count = sharpened_q.size();

  function automatic int eff_width();
    if (img_w == 0) return 1;
    return (img_w > MAXW) ? MAXW : int'(img_w);
  endfunction

  function automatic int eff_height();
    return (img_h == 0) ? 1 : int'(img_h);
  endfunction

  function automatic int eff_radius();
    if (radius == 0) return 1;
    return (radius > MAXR) ? MAXR : int'(radius);
  endfunction

  function automatic longint tap(input int d);
    if (d * WEIGHT_BITS >= CFG_W_BITS) return 0;
    return longint'((weights >> (d * WEIGHT_BITS)) & 60'hFFF);
  endfunction

  function automatic int mem_addr(input int r, input int c, input int w);
    return int'((longint'(r) * w + c) % DEPTH);
  endfunction

  // Pixel at column k of the row whose newest column is j, with edge replication.
  function automatic longint win_pixel(input int k, input int j);
    int kk, p;
    kk = (k < 0) ? 0 : ((k > j) ? j : k);
    p = j - kk;
    if (p > WINN - 1) p = WINN - 1;
    return longint'(row_win[p]);
  endfunction

  task automatic hblur_column(input int r, input int c, input int j, input int w,
                              input int rad);
    longint sum, hb;
    sum = 0;
    for (int d = -rad; d <= rad; d++) sum += tap(d < 0 ? -d : d) * win_pixel(c + d, j);
    hb = (sum + HB_RND) >>> HB_SHIFT;
    if (hb > 64'hFFFFF) hb = 64'hFFFFF;
    hblur_mem[mem_addr(r, c, w)] = hb[HB_BITS-1:0];
  endtask

  function automatic logic [PIX_BITS-1:0] sharpen_pixel(input int y, input int x, input int w,
                                                       input int h, input int rad);
    longint vs, orig, blur, diff, adiff, s, lim, ry;
    vs = 0;
    for (int d = -rad; d <= rad; d++) begin
      ry = y + d;
      if (ry < 0) ry = 0;
      if (ry > h - 1) ry = h - 1;
      vs += tap(d < 0 ? -d : d) * longint'(hblur_mem[mem_addr(int'(ry), x, w)]);
    end
    blur = (vs + 2048) >>> 12;
    orig = longint'(orig_mem[mem_addr(y, x, w)]);
    diff = orig * 16 - blur;
    adiff = (diff < 0) ? -diff : diff;
    if (adiff < longint'(thresh) * 16) return orig[PIX_BITS-1:0];
    s = orig * 4096 + longint'(gain) * diff;
    lim = longint'(gain) * longint'(thresh) * 16;
    if (s > orig * 4096 + lim) s = orig * 4096 + lim;
    if (s < orig * 4096 - lim) s = orig * 4096 - lim;
    if (s < 0) return '0;
    s = (s + 2048) >>> 12;
    return (s > 65535) ? 16'hFFFF : s[PIX_BITS-1:0];
  endfunction

  task automatic restart_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    for (int i = 0; i < WINN; i++) row_win[i] = '0;
  endtask

  task automatic predict_transaction(input logic cmd, input logic [PIX_BITS-1:0] pix);
    int w, h, rad, j, c;
    longint total, lag, oidx;
    logic emit;
    sharp_result_t res;
    w = eff_width(); h = eff_height(); rad = eff_radius();
    total = longint'(w) * h;
    lag = longint'(rad) * w + rad;
    oidx = longint'(out_row) * w + out_col;
    emit = 1'b0;
    if (cmd == CMD_PIXEL && in_row < h) begin
      j = in_col;
      orig_mem[mem_addr(in_row, j, w)] = pix;
      for (int p = WINN - 1; p > 0; p--) row_win[p] = (j == 0) ? pix : row_win[p-1];
      row_win[0] = pix;
      if (j >= rad) hblur_column(in_row, j - rad, j, w, rad);
      if (j == w - 1) begin
        c = j - rad + 1;
        if (c < 0) c = 0;
        for (; c <= j; c++) hblur_column(in_row, c, j, w, rad);
      end
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      emit = (longint'(in_row) * w + in_col) >= lag + oidx + 1;
    end else if (in_row >= h && oidx < total) begin
      emit = 1'b1;
    end
    if (emit) begin
      res.pix = sharpen_pixel(out_row, out_col, w, h, rad);
      res.eor = (out_col == w - 1);
      res.eof = (oidx + 1 == total);
      sharpened_q.push_back(res);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      if (oidx + 1 >= total) restart_frame();
    end
  endtask

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  initial mismatch_count = 0;

  always @(posedge clk) begin
    sharp_result_t exp_r;
    if (!rst_n) begin
      img_w = RST_IMAGE_WIDTH;
      img_h = RST_IMAGE_HEIGHT;
      radius = RST_RADIUS;
      weights = RST_WEIGHTS;
      gain = RST_AMOUNT;
      thresh = RST_THRESHOLD;
      restart_frame();
      sharpened_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:    img_w = cfg_data[12:0];
          CFG_IMAGE_HEIGHT:   img_h = cfg_data[15:0];
          CFG_KERNEL_RADIUS:  radius = cfg_data[2:0];
          CFG_KERNEL_WEIGHTS: weights = cfg_data[CFG_W_BITS-1:0];
          CFG_AMOUNT:         gain = cfg_data[AMT_BITS-1:0];
          CFG_THRESHOLD:      thresh = cfg_data[THR_BITS-1:0];
          default: ;
        endcase
        if (cfg_index <= CFG_THRESHOLD) restart_frame();
      end
      if (in_valid && in_ready) predict_transaction(in_command, in_pixel_in);
      if (out_valid && out_ready) begin
        if (sharpened_q.size() == 0) begin
          report($sformatf("result %h with nothing expected", out_pixel_out));
        end else begin
          exp_r = sharpened_q.pop_front();
          if (out_pixel_out !== exp_r.pix)
            report($sformatf("pixel_out %h, expected %h", out_pixel_out, exp_r.pix));
          if (out_end_of_row !== exp_r.eor)
            report($sformatf("end_of_row %b, expected %b", out_end_of_row, exp_r.eor));
          if (out_end_of_frame !== exp_r.eof)
            report($sformatf("end_of_frame %b, expected %b", out_end_of_frame, exp_r.eof));
        end
      end
    end
  end

endmodule

>>> test/tb_unsharp_mask_stream_unit.sv
`timescale 1ns / 1ps
// Testbench top that drives frames and configuration into the unsharp mask unit.
module tb_unsharp_mask_stream_unit;
  import umask_pkg::*;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_command;
  logic [PIX_BITS-1:0]      in_pixel_in;
  logic                     out_valid;
  logic                     out_ready;
  logic [PIX_BITS-1:0]      out_pixel_out;
  logic                     out_end_of_row;
  logic                     out_end_of_frame;
  logic                     cfg_wr_en;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int                       mismatch_count;
  int                       pending_count;

  // When set, both the sender and the receiver insert random bubbles.
  logic bubbles_on;
  int   items_sent;
  logic [2:0]  cur_r;

  unsharp_mask_stream_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_out(out_pixel_out), .out_end_of_row(out_end_of_row),
    .out_end_of_frame(out_end_of_frame),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  umask_sharpen_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_out(out_pixel_out), .out_end_of_row(out_end_of_row),
    .out_end_of_frame(out_end_of_frame),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls in about a quarter of the cycles while bubbles are on.
  always @(posedge clk) begin
    out_ready <= bubbles_on ? ($urandom_range(0, 99) >= 25) : 1'b1;
  end

  // Watchdog: the slowest legal run is far shorter than this.
  initial begin
    #100ms;
    $display("tb_unsharp_mask_stream_unit: errors");
    $finish;
  end

  // Sends one transaction. It is called at a rising edge and returns at the edge
  // where the transaction is accepted, leaving valid high so that the next call
  // can follow back to back. in_ready only moves at rising edges, so the value
  // seen at the falling edge is the one the next rising edge will use.
  task automatic send_item(input logic cmd, input logic [PIX_BITS-1:0] pix);
    if (bubbles_on && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_pixel_in <= pix;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  // Waits until every predicted result has left the block and then for the
  // longest processing time of a transaction that yields nothing, so that a
  // register write finds the block idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_KERNEL_RADIUS) cur_r = val[2:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic configure(input logic [12:0] w, input logic [15:0] h, input logic [2:0] r,
                           input logic [59:0] wts, input logic [10:0] amt,
                           input logic [15:0] thr);
    settle();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
    write_reg(CFG_KERNEL_RADIUS, CFG_DATA_BITS'(r));
    write_reg(CFG_KERNEL_WEIGHTS, CFG_DATA_BITS'(wts));
    write_reg(CFG_AMOUNT, CFG_DATA_BITS'(amt));
    write_reg(CFG_THRESHOLD, CFG_DATA_BITS'(thr));
  endtask

  function automatic logic [PIX_BITS-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // A plausible low-pass kernel most of the time, raw register contents otherwise.
  function automatic logic [59:0] rand_weights();
    logic [59:0] v;
    if ($urandom_range(0, 3) == 0) return 60'({$urandom, $urandom});
    v = '0;
    v[11:0] = 12'($urandom_range(1000, 4095));
    for (int i = 1; i < 5; i++) v[i*12 +: 12] = 12'($urandom_range(0, 1200));
    return v;
  endfunction

  // Streams a whole frame with occasional stray drains, then enough drains (and
  // sometimes stray pixels, which act as drains) to flush the pending rows.
  // An abandoned frame streams at most its first 64 pixels.
  task automatic send_frame(input int w, input int h, input logic abort);
    int n, r, flush;
    n = abort ? $urandom_range(1, (w * h > 64) ? 64 : w * h) : w * h;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 4) send_item(CMD_DRAIN, 16'($urandom));
      send_item(CMD_PIXEL, rand_pixel());
    end
    if (abort) return;
    r = (cur_r == 0) ? 1 : ((cur_r > 4) ? 4 : int'(cur_r));
    flush = r * w + r + $urandom_range(0, 2);
    for (int i = 0; i < flush; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(CMD_PIXEL, rand_pixel());
      else send_item(CMD_DRAIN, 16'($urandom));
    end
  endtask

  initial begin
    int w, h, ew, eh;
    logic [10:0] amt;
    logic [15:0] thr;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_PIXEL;
    in_pixel_in = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_data = '0;
    bubbles_on = 1'b0;
    items_sent = 0;
    cur_r = RST_RADIUS;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a row of extremes plus a stray drain, far from any output.
    send_item(CMD_PIXEL, 16'h0000);
    send_item(CMD_PIXEL, 16'hFFFF);
    send_item(CMD_DRAIN, 16'hFFFF);
    send_item(CMD_PIXEL, 16'hFFFF);
    send_item(CMD_PIXEL, 16'h0000);

    // Tiny frame with full gain and zero threshold: a drain before the end of the
    // frame is ignored, a pixel after the frame acts as a drain, and a drain with
    // nothing pending gives nothing.
    configure(13'd3, 16'd2, 3'd1, rand_weights(), 11'd1280, 16'd0);
    send_item(CMD_PIXEL, 16'hFFFF);
    send_item(CMD_PIXEL, 16'h0000);
    send_item(CMD_DRAIN, 16'h1234);
    send_item(CMD_PIXEL, 16'hFFFF);
    send_item(CMD_PIXEL, 16'h0000);
    send_item(CMD_PIXEL, 16'hFFFF);
    send_item(CMD_PIXEL, 16'h0000);
    send_item(CMD_PIXEL, 16'h5555);
    send_item(CMD_DRAIN, 16'h0000);
    send_item(CMD_DRAIN, 16'h0000);
    send_item(CMD_DRAIN, 16'h0000);
    send_item(CMD_DRAIN, 16'h0000);

    // Zero width, height and radius act as one; amount zero passes pixels through.
    configure(13'd0, 16'd0, 3'd0, 60'h0, 11'd0, 16'hFFFF);
    send_frame(1, 1, 1'b0);
    configure(13'd4, 16'd3, 3'd7, 60'({$urandom, $urandom}), 11'h7FF, 16'd1);
    send_frame(4, 3, 1'b0);

    // Tallest frame: only its start is streamed before it is abandoned.
    configure(13'd1, 16'hFFFF, 3'd4, rand_weights(), 11'd640, 16'd20);
    send_frame(1, 65535, 1'b1);

    // Random frames, mostly small, with bubbles in most of them.
    while (items_sent < 1200) begin
      bubbles_on = ($urandom_range(0, 4) != 0);
      w = $urandom_range(0, 12);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
      case ($urandom_range(0, 5))
        0: amt = 11'd0;
        1: amt = 11'd1280;
        2: amt = 11'($urandom);
        default: amt = 11'($urandom_range(1, 1280));
      endcase
      case ($urandom_range(0, 5))
        0: thr = 16'd0;
        1: thr = 16'hFFFF;
        2: thr = 16'($urandom);
        default: thr = 16'($urandom_range(0, 300));
      endcase
      configure(w[12:0], h[15:0], 3'($urandom_range(0, 7)), rand_weights(), amt, thr);
      ew = (w == 0) ? 1 : w;
      eh = (h == 0) ? 1 : h;
      send_frame(ew, eh, $urandom_range(0, 9) == 0);
    end

    // Widest row: the width register's top value acts as the maximum width, so
    // the start of the row stays far from any output before it is abandoned.
    bubbles_on = 1'b0;
    configure(13'h1FFF, 16'd1, 3'd1, rand_weights(), 11'd300, 16'd2);
    send_frame(4096, 1, 1'b1);

    settle();
    if (mismatch_count == 0) begin
      $display("tb_unsharp_mask_stream_unit: clean");
    end else begin
      $display("tb_unsharp_mask_stream_unit: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/umask_pkg.sv
design/umask_row_mem.sv
design/umask_sharp.sv
design/unsharp_mask_stream_unit.sv
test/umask_sharpen_checker.sv
test/tb_unsharp_mask_stream_unit.sv
